// ===== hw/rtl/lgpg_pkg.sv =====
// Package for the linear gradient pixel generator: widths, register indexes,
// pixel region codes and premultiply constants. No dependencies.
package lgpg_pkg;

    localparam int COORD_BITS    = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int WIDTH_BITS    = 15;
    localparam int CHAN_BITS     = 8;
    localparam int NUM_CHAN      = 4;
    localparam int FRAC_BITS     = 16;

    localparam int DIVD_BITS    = CHAN_BITS + FRAC_BITS;
    localparam int STEP_BITS    = DIVD_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(DIVD_BITS);
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST_CNT = DIV_CNT_BITS'(DIVD_BITS - 1);

    localparam int CMP_BITS  = ((COORD_BITS > WIDTH_BITS) ? COORD_BITS : WIDTH_BITS) + 1;
    localparam int PROD_BITS = WIDTH_BITS + 1 + STEP_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;

    localparam int PREMUL_SCALE_BITS = 9;
    localparam int PREMUL_SUM_BITS   = 2 * CHAN_BITS + 1;
    localparam int PREMUL_PROD_BITS  = PREMUL_SUM_BITS + PREMUL_SCALE_BITS;

    localparam logic [CHAN_BITS-1:0]         PREMUL_ROUND = 8'h80;
    localparam logic [PREMUL_SCALE_BITS-1:0] PREMUL_SCALE = 9'h101;
    localparam logic [CHAN_BITS-1:0]         CHAN_MAX     = 8'hFF;

    typedef logic [CHAN_BITS-1:0] chan_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COLOR_START,
        REG_COLOR_END,
        REG_GRADIENT_WIDTH,
        REG_PREMULTIPLY_MODE
    } cfg_reg_t;

    typedef enum logic [1:0] {
        REGION_START,
        REGION_INTERP,
        REGION_END
    } region_t;

endpackage

// ===== hw/rtl/lgpg_ifs.sv =====
// Channel interfaces of the linear gradient pixel generator: configuration
// writes, pixel coordinates in, ARGB pixels out. Depends on lgpg_pkg.
interface lgpg_cfg_if import lgpg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface lgpg_coord_if import lgpg_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;

    modport source (output valid, output pixel_x, input ready);
    modport sink   (input valid, input pixel_x, output ready);
endinterface

interface lgpg_color_if import lgpg_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t out_alpha;
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;

    modport source (output valid, output out_alpha, output out_red, output out_green,
                    output out_blue, input ready);
    modport sink   (input valid, input out_alpha, input out_red, input out_green,
                    input out_blue, output ready);
endinterface

// ===== hw/rtl/linear_gradient_pixel_gen.sv =====
// Linear ARGB gradient pixel generator: top level, five-stage pixel pipeline
// and bit-serial step divider. Depends on lgpg_pkg and lgpg_ifs.
//
// One pixel coordinate beat on coord yields one ARGB beat on color, presented
// from the stage 5 register, at one pixel per clock when nothing stalls;
// each stage holds its beat under back-pressure and a free stage accepts the
// next one. The per-channel signed 9.16 steps come from a four-lane restoring
// divider that produces one quotient bit per clock: coord.ready stays low
// during a configuration beat and after it while the steps are recomputed.
// Configuration beats are always accepted and must only be sent while no pixel
// is in flight.
module linear_gradient_pixel_gen import lgpg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    lgpg_cfg_if.sink    cfg,
    lgpg_coord_if.sink  coord,
    lgpg_color_if.source color
);

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_RUN
    } div_state_t;

    logic [CFG_DATA_BITS-1:0] color_start_reg;
    logic [CFG_DATA_BITS-1:0] color_end_reg;
    logic [WIDTH_BITS-1:0]    gradient_width_reg;
    logic                     premultiply_mode_reg;

    logic                  cfg_write;
    logic [WIDTH_BITS-1:0] last;
    chan_t                 start_chan [NUM_CHAN];
    chan_t                 end_chan   [NUM_CHAN];

    div_state_t              div_state_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;
    logic [DIVD_BITS-1:0]    div_quo_reg  [NUM_CHAN];
    logic [WIDTH_BITS-1:0]   div_rem_reg  [NUM_CHAN];
    logic                    div_neg_reg  [NUM_CHAN];
    logic [DIVD_BITS-1:0]    div_quo_next [NUM_CHAN];
    logic [WIDTH_BITS-1:0]   div_rem_next [NUM_CHAN];
    logic [DIVD_BITS-1:0]    load_mag     [NUM_CHAN];
    logic                    load_neg     [NUM_CHAN];
    logic [STEP_BITS-1:0]    step_next    [NUM_CHAN];
    logic signed [STEP_BITS-1:0] step_reg [NUM_CHAN];
    logic                    busy;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic coord_accept;

    logic signed [CMP_BITS-1:0] x_ext;
    logic signed [CMP_BITS-1:0] last_ext;
    region_t                    region_in;

    region_t               s1_region_reg;
    logic [WIDTH_BITS-1:0] s1_x_reg;
    region_t               s2_region_reg;
    logic signed [PROD_BITS-1:0] s2_prod_reg [NUM_CHAN];
    chan_t                 s3_chan_next [NUM_CHAN];
    chan_t                 s3_chan_reg  [NUM_CHAN];
    chan_t                 s4_chan_reg  [NUM_CHAN];
    logic [2*CHAN_BITS-1:0] s4_mul_reg  [1:NUM_CHAN-1];
    chan_t                 s5_chan_next [NUM_CHAN];
    chan_t                 s5_chan_reg  [NUM_CHAN];

    // Configuration registers
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_start_reg      <= '0;
            color_end_reg        <= '0;
            gradient_width_reg   <= '0;
            premultiply_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_COLOR_START:      color_start_reg      <= cfg.data;
                REG_COLOR_END:        color_end_reg        <= cfg.data;
                REG_GRADIENT_WIDTH:   gradient_width_reg   <= cfg.data[WIDTH_BITS-1:0];
                REG_PREMULTIPLY_MODE: premultiply_mode_reg <= cfg.data[0];
            endcase
        end
    end

    assign last = (gradient_width_reg == '0) ? '0 : gradient_width_reg - WIDTH_BITS'(1);

    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            start_chan[k] = color_start_reg[(NUM_CHAN-1-k)*CHAN_BITS +: CHAN_BITS];
            end_chan[k]   = color_end_reg[(NUM_CHAN-1-k)*CHAN_BITS +: CHAN_BITS];
        end
    end

    // Step divider: |c1 - c0| << 16 divided by last, one quotient bit per clock
    always_comb
    begin
        logic [CHAN_BITS:0]    diff;
        logic [WIDTH_BITS:0]   rem_sh;
        logic                  ge;
        logic [STEP_BITS-1:0]  q_ext;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            diff        = {1'b0, end_chan[k]} - {1'b0, start_chan[k]};
            load_neg[k] = diff[CHAN_BITS];
            load_mag[k] = {(diff[CHAN_BITS] ? CHAN_BITS'(-diff) : diff[CHAN_BITS-1:0]),
                           FRAC_BITS'(0)};

            rem_sh          = {div_rem_reg[k], div_quo_reg[k][DIVD_BITS-1]};
            ge              = rem_sh >= {1'b0, last};
            div_rem_next[k] = ge ? WIDTH_BITS'(rem_sh - {1'b0, last})
                                 : rem_sh[WIDTH_BITS-1:0];
            div_quo_next[k] = {div_quo_reg[k][DIVD_BITS-2:0], ge};

            q_ext = STEP_BITS'(div_quo_next[k]);
            if (last == '0)
                step_next[k] = '0;
            else if (div_neg_reg[k])
                step_next[k] = ~q_ext + STEP_BITS'(1);
            else
                step_next[k] = q_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_state_reg <= DIV_IDLE;
            div_cnt_reg   <= '0;
            for (int k = 0; k < NUM_CHAN; k++)
                step_reg[k] <= '0;
        end
        else if (cfg_write)
        begin
            div_state_reg <= DIV_LOAD;
        end
        else
        begin
            unique case (div_state_reg)
                DIV_IDLE:
                begin
                    div_state_reg <= DIV_IDLE;
                end
                DIV_LOAD:
                begin
                    div_state_reg <= DIV_RUN;
                    div_cnt_reg   <= '0;
                end
                DIV_RUN:
                begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_BITS'(1);
                    if (div_cnt_reg == DIV_LAST_CNT)
                    begin
                        div_state_reg <= DIV_IDLE;
                        for (int k = 0; k < NUM_CHAN; k++)
                            step_reg[k] <= signed'(step_next[k]);
                    end
                end
                default:
                begin
                    div_state_reg <= DIV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            if (div_state_reg == DIV_LOAD)
            begin
                div_quo_reg[k] <= load_mag[k];
                div_rem_reg[k] <= '0;
                div_neg_reg[k] <= load_neg[k];
            end
            else if (div_state_reg == DIV_RUN)
            begin
                div_quo_reg[k] <= div_quo_next[k];
                div_rem_reg[k] <= div_rem_next[k];
            end
        end
    end

    assign busy = div_state_reg != DIV_IDLE;

    // Pipeline handshake: a stage loads when it is empty or its beat moves on
    assign rdy5 = !v5_reg || color.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign coord.ready  = rdy1 && !busy && !cfg.valid;
    assign coord_accept = coord.valid && coord.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= coord_accept;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: classify the coordinate
    assign x_ext    = CMP_BITS'(coord.pixel_x);
    assign last_ext = CMP_BITS'(last);

    always_comb
    begin
        if (x_ext < 0)
            region_in = REGION_START;
        else if (x_ext < last_ext)
            region_in = REGION_INTERP;
        else
            region_in = REGION_END;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && coord_accept)
        begin
            s1_region_reg <= region_in;
            s1_x_reg      <= x_ext[WIDTH_BITS-1:0];
        end
    end

    // Stage 2: x * step per channel
    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            s2_region_reg <= s1_region_reg;
            for (int k = 0; k < NUM_CHAN; k++)
                s2_prod_reg[k] <= PROD_BITS'($signed({1'b0, s1_x_reg}) * step_reg[k]);
        end
    end

    // Stage 3: add the start colour, clamp, pick the region
    always_comb
    begin
        logic signed [SUM_BITS-1:0] sum;
        chan_t                      interp;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            sum = SUM_BITS'($signed({1'b0, start_chan[k], FRAC_BITS'(0)}))
                + SUM_BITS'(s2_prod_reg[k]);
            if (sum[SUM_BITS-1])
                interp = '0;
            else if (|sum[SUM_BITS-2:FRAC_BITS+CHAN_BITS])
                interp = CHAN_MAX;
            else
                interp = sum[FRAC_BITS +: CHAN_BITS];

            case (s2_region_reg)
                REGION_START:  s3_chan_next[k] = start_chan[k];
                REGION_INTERP: s3_chan_next[k] = interp;
                REGION_END:    s3_chan_next[k] = end_chan[k];
                default:       s3_chan_next[k] = end_chan[k];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            for (int k = 0; k < NUM_CHAN; k++)
                s3_chan_reg[k] <= s3_chan_next[k];
        end
    end

    // Stage 4: colour times alpha
    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            for (int k = 0; k < NUM_CHAN; k++)
                s4_chan_reg[k] <= s3_chan_reg[k];
            for (int k = 1; k < NUM_CHAN; k++)
                s4_mul_reg[k] <= s3_chan_reg[k] * s3_chan_reg[0];
        end
    end

    // Stage 5: round and scale by 257/65536, or pass through
    always_comb
    begin
        logic [PREMUL_PROD_BITS-1:0] scaled;
        s5_chan_next[0] = s4_chan_reg[0];
        for (int k = 1; k < NUM_CHAN; k++)
        begin
            scaled = PREMUL_PROD_BITS'(PREMUL_PROD_BITS'(s4_mul_reg[k])
                                       + PREMUL_PROD_BITS'(PREMUL_ROUND))
                   * PREMUL_PROD_BITS'(PREMUL_SCALE);
            s5_chan_next[k] = premultiply_mode_reg ? scaled[FRAC_BITS +: CHAN_BITS]
                                                   : s4_chan_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            for (int k = 0; k < NUM_CHAN; k++)
                s5_chan_reg[k] <= s5_chan_next[k];
        end
    end

    assign color.valid     = v5_reg;
    assign color.out_alpha = s5_chan_reg[0];
    assign color.out_red   = s5_chan_reg[1];
    assign color.out_green = s5_chan_reg[2];
    assign color.out_blue  = s5_chan_reg[3];

    // Assertions
    a_no_pixel_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        coord_accept |-> div_state_reg == DIV_IDLE)
        else $error("pixel beat accepted while steps are being recomputed");

    a_cfg_blocks_coord: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !coord.ready)
        else $error("coord ready right after a configuration beat");

    a_zero_span_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
        (div_state_reg == DIV_RUN && div_cnt_reg == DIV_LAST_CNT && last == '0 && !cfg_write)
        |=> (step_reg[0] == '0 && step_reg[1] == '0 && step_reg[2] == '0
             && step_reg[3] == '0))
        else $error("nonzero step for a gradient without interior pixels");

    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdy3) |=> (v3_reg && $stable(s3_chan_reg[0]) && $stable(s3_chan_reg[1])
                               && $stable(s3_chan_reg[2]) && $stable(s3_chan_reg[3])))
        else $error("stalled beat lost in stage 3");

endmodule

// ===== test/tb_linear_gradient_pixel_gen.sv =====
`timescale 1ns / 1ps
// Testbench for linear_gradient_pixel_gen: random and directed pixel coordinates under
// changing gradient settings, checked against a local ARGB predictor in a scoreboard.
// Depends on lgpg_pkg, lgpg_ifs and the linear_gradient_pixel_gen RTL.
module tb_linear_gradient_pixel_gen;
    import lgpg_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_PIXELS = 125;

    typedef struct packed {
        chan_t alpha;
        chan_t red;
        chan_t green;
        chan_t blue;
    } argb_t;

    class gradient_scoreboard;
        logic [CFG_DATA_BITS-1:0] c_start;
        logic [CFG_DATA_BITS-1:0] c_end;
        logic [WIDTH_BITS-1:0]    grad_width;
        logic                     premul;
        argb_t                    pending_colors[$];
        int                       mismatches;
        int                       pixels_in;

        function new();
            c_start    = '0;
            c_end      = '0;
            grad_width = '0;
            premul     = 1'b0;
            mismatches = 0;
            pixels_in  = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] d);
            case (idx)
                REG_COLOR_START:      c_start    = d;
                REG_COLOR_END:        c_end      = d;
                REG_GRADIENT_WIDTH:   grad_width = d[WIDTH_BITS-1:0];
                REG_PREMULTIPLY_MODE: premul     = d[0];
                default: ;
            endcase
        endfunction

        function argb_t gradient_color(logic signed [COORD_BITS-1:0] x);
            longint      px;
            longint      last;
            longint      diff;
            longint      step;
            longint      val;
            int unsigned c0;
            int unsigned c1;
            int unsigned ch[4];
            argb_t       p;
            px   = x;
            last = (grad_width != 0) ? longint'(grad_width) - 1 : 0;
            for (int k = 0; k < NUM_CHAN; k++) begin
                c0 = (c_start >> (24 - 8 * k)) & 32'hFF;
                c1 = (c_end >> (24 - 8 * k)) & 32'hFF;
                if (px < 0) begin
                    ch[k] = c0;
                end else if (px < last) begin
                    diff = longint'(c1) - longint'(c0);
                    step = (diff * 65536) / last;
                    val  = longint'(c0) * 65536 + px * step;
                    if (val < 0)
                        ch[k] = 0;
                    else if ((val >>> FRAC_BITS) > 255)
                        ch[k] = 255;
                    else
                        ch[k] = int'(val >>> FRAC_BITS);
                end else begin
                    ch[k] = c1;
                end
            end
            if (premul) begin
                for (int k = 1; k < NUM_CHAN; k++)
                    ch[k] = (((ch[k] * ch[0]) + 32'h80) * 32'h101) >> 16;
            end
            p.alpha = ch[0][7:0];
            p.red   = ch[1][7:0];
            p.green = ch[2][7:0];
            p.blue  = ch[3][7:0];
            return p;
        endfunction

        function void note_pixel(logic signed [COORD_BITS-1:0] x);
            pending_colors.push_back(gradient_color(x));
            pixels_in++;
        endfunction

        function void check_field(string name, chan_t want, chan_t got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_pixel(argb_t got);
            argb_t want;
            if (pending_colors.size() == 0) begin
                $error("unexpected pixel beat: %h", got);
                mismatches++;
                return;
            end
            want = pending_colors.pop_front();
            check_field("out_alpha", want.alpha, got.alpha);
            check_field("out_red",   want.red,   got.red);
            check_field("out_green", want.green, got.green);
            check_field("out_blue",  want.blue,  got.blue);
        endfunction

        function int pending();
            return pending_colors.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_gaps;
    int   settings_seen;

    gradient_scoreboard sb = new();

    lgpg_cfg_if   cfg_bus();
    lgpg_coord_if coord_bus();
    lgpg_color_if color_bus();

    linear_gradient_pixel_gen dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .coord (coord_bus),
        .color (color_bus)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // drop ready at random, except in the gap-free stretch
    initial
    begin
        color_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            color_bus.ready <= no_gaps || ($urandom_range(99) >= 29);
        end
    end

    initial
    begin
        argb_t got;
        forever
        begin
            @(posedge clk);
            if (color_bus.valid && color_bus.ready)
            begin
                got.alpha = color_bus.out_alpha;
                got.red   = color_bus.out_red;
                got.green = color_bus.out_green;
                got.blue  = color_bus.out_blue;
                sb.check_pixel(got);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cfg_bus.valid && cfg_bus.ready) || (coord_bus.valid && coord_bus.ready) ||
                (color_bus.valid && color_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no beat moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] d);
        while (!no_gaps && $urandom_range(99) < 29)
        begin
            cfg_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= d;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        sb.write_reg(idx, d);
        @(negedge clk);
    endtask

    task automatic set_gradient(logic [31:0] c0, logic [31:0] c1, logic [31:0] w_word,
                                logic [31:0] m_word);
        cfg_write(REG_COLOR_START, c0);
        cfg_write(REG_COLOR_END, c1);
        cfg_write(REG_GRADIENT_WIDTH, w_word);
        cfg_write(REG_PREMULTIPLY_MODE, m_word);
        cfg_bus.valid <= 1'b0;
        settings_seen++;
    endtask

    task automatic send_pixel(logic signed [COORD_BITS-1:0] x);
        while (!no_gaps && $urandom_range(99) < 29)
        begin
            coord_bus.valid <= 1'b0;
            @(negedge clk);
        end
        coord_bus.valid   <= 1'b1;
        coord_bus.pixel_x <= x;
        @(posedge clk);
        while (!coord_bus.ready)
            @(posedge clk);
        sb.note_pixel(x);
        @(negedge clk);
    endtask

    task automatic send_list(int xs[$]);
        foreach (xs[i])
            send_pixel(COORD_BITS'(xs[i]));
    endtask

    // hold off the coordinate side until every pixel in flight has come back
    task automatic drain_pixels();
        coord_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_pixel(int last);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 8)
            v = $urandom;
        else if (r < 18)
            v = -int'($urandom_range(16, 1));
        else if (r < 35)
            v = last + int'($urandom_range(4)) - 2;
        else
            v = int'($urandom_range(last + 2));
        return COORD_BITS'(v);
    endfunction

    function automatic int pick_width();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 32767;
            4, 5:    return $urandom_range(3000, 41);
            default: return $urandom_range(40, 3);
        endcase
    endfunction

    function automatic logic [31:0] pick_color();
        case ($urandom_range(4))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int w;
        int last;
        rst_n             = 1'b0;
        no_gaps           = 1'b0;
        settings_seen     = 0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = REG_COLOR_START;
        cfg_bus.data      = '0;
        coord_bus.valid   = 1'b0;
        coord_bus.pixel_x = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_gradient(32'h80FF_0040, 32'hFF00_FFC0, 32'hFFFE_0011, 32'h0000_0000);
        send_list('{-32768, -1, 0, 1, 7, 15, 16, 17, 32767});
        drain_pixels();
        set_gradient(32'h80FF_0040, 32'hFF00_FFC0, 32'd17, 32'hFFFF_FFFF);
        send_list('{0, 8, 16});
        drain_pixels();
        set_gradient(32'h1234_5678, 32'h9ABC_DEF0, 32'd0, 32'd0);
        send_list('{-1, 0, 9});
        drain_pixels();
        set_gradient(32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_8001, 32'hFFFF_FFFE);
        send_list('{-5, 0, 1});
        drain_pixels();
        set_gradient(32'h0000_0000, 32'hFFFF_FFFF, 32'd32767, 32'd1);
        send_list('{32764, 32765, 32766, 32767});
        drain_pixels();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            no_gaps = (p == 2);
            w       = pick_width();
            last    = (w != 0) ? w - 1 : 0;
            set_gradient(pick_color(), pick_color(),
                         {17'($urandom_range(32'h1FFFF)), 15'(w)},
                         {31'($urandom_range(32'h7FFF_FFFF)), 1'($urandom_range(1))});
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                if (p == 5 && i == PHASE_PIXELS / 2)
                    drain_pixels();
                send_pixel(pick_pixel(last));
            end
            drain_pixels();
        end
        no_gaps = 1'b0;

        repeat (20) @(posedge clk);
        $display("Checked %0d pixels over %0d gradient settings (widths 0 to 32767,",
                 sb.pixels_in, settings_seen);
        $display("plain and premultiplied, edge and out-of-range coordinates).");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
